/* src/capv_pkg.sv */
`timescale 1ns / 1ps

package capv_pkg;

  // Status codes reported with every result word.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd1;
  localparam logic [2:0] ST_NULL      = 3'd2;
  localparam logic [2:0] ST_START_OUT = 3'd3;
  localparam logic [2:0] ST_END_OUT   = 3'd4;
  localparam logic [2:0] ST_BAD_TAG   = 3'd5;
  localparam logic [2:0] ST_SIZE_MIS  = 3'd6;

  // Pointer type codes and the composite element size code.
  localparam logic [1:0] PT_STRUCT = 2'd0;
  localparam logic [1:0] PT_LIST   = 2'd1;
  localparam logic [2:0] ET_COMPOSITE = 3'd7;

  // Element size codes of non-composite lists.
  localparam logic [2:0] ET_VOID  = 3'd0;
  localparam logic [2:0] ET_BIT   = 3'd1;
  localparam logic [2:0] ET_BYTE  = 3'd2;
  localparam logic [2:0] ET_TWO   = 3'd3;
  localparam logic [2:0] ET_FOUR  = 3'd4;
  localparam logic [2:0] ET_EIGHT = 3'd5;
  localparam logic [2:0] ET_PTR   = 3'd6;

  localparam int LEN_W  = 29;
  localparam int SIZE_W = 17;

  // One classified word as it travels from the front part to the back part.
  typedef struct packed {
    logic [2:0]              status;
    logic                    kind;
    logic signed [30:0]      tgt;
    logic [15:0]             dw;
    logic [15:0]             pc;
    logic [LEN_W-1:0]        ec;
    logic [19:0]             stride;
    logic [2:0]              et;
    logic                    comp;
    logic [SIZE_W-1:0]       size;
  } item_t;

  // One stage of the restoring divider.
  typedef struct packed {
    item_t              it;
    logic [SIZE_W-1:0]  rem;
    logic [LEN_W-1:0]   quo;
    logic [LEN_W-1:0]   dvd;
  } stage_t;

  // Stride in bytes of a non-composite element size code.
  function automatic logic [19:0] stride_of(input logic [2:0] et);
    logic [19:0] s;
    case (et)
      ET_BYTE:  s = 20'd1;
      ET_TWO:   s = 20'd2;
      ET_FOUR:  s = 20'd4;
      ET_EIGHT: s = 20'd8;
      ET_PTR:   s = 20'd8;
      default:  s = 20'd0;
    endcase
    return s;
  endfunction

  // One step of restoring division: shift in the next dividend bit.
  function automatic stage_t div_step(input stage_t s);
    stage_t            o;
    logic [SIZE_W:0]   r;
    o = s;
    r = {s.rem, s.dvd[LEN_W-1]};
    if (r >= {1'b0, s.it.size}) begin
      o.rem = SIZE_W'(r - {1'b0, s.it.size});
      o.quo = {s.quo[LEN_W-2:0], 1'b1};
    end else begin
      o.rem = r[SIZE_W-1:0];
      o.quo = {s.quo[LEN_W-2:0], 1'b0};
    end
    o.dvd = {s.dvd[LEN_W-2:0], 1'b0};
    return o;
  endfunction

endpackage

/* src/capv_front.sv */
`timescale 1ns / 1ps

module capv_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [63:0]         in_pointer_word,
  input  logic [63:0]         in_tag_word,
  input  logic signed [29:0]  in_dist_to_start,
  input  logic [29:0]         in_dist_to_end,
  output logic                fq_push,
  input  logic                fq_full,
  output capv_pkg::item_t     fq_item
);

  logic             vld_r, vld_nxt;
  capv_pkg::item_t  item_r, item_nxt;

  logic [1:0]              typ;
  logic [2:0]              et;
  logic [28:0]             len;
  logic [29:0]             lw, total;
  logic signed [30:0]      start;
  logic signed [32:0]      start33, end33, lo33, hi33;
  logic [15:0]             sdw, spc, tdw, tpc;
  logic [16:0]             ssize, tsize;
  logic                    tag_bad, start_ok, end_ok;

  // Field extraction and list size in words.
  always_comb begin
    typ   = in_pointer_word[1:0];
    et    = in_pointer_word[34:32];
    len   = in_pointer_word[63:35];
    sdw   = in_pointer_word[47:32];
    spc   = in_pointer_word[63:48];
    tdw   = in_tag_word[47:32];
    tpc   = in_tag_word[63:48];
    ssize = {1'b0, sdw} + {1'b0, spc};
    tsize = {1'b0, tdw} + {1'b0, tpc};
    start = 31'(signed'(in_pointer_word[31:2])) + 31'sd1;
    lw    = {1'b0, len};
    case (et)
      capv_pkg::ET_BIT:       total = (lw + 30'd63) >> 6;
      capv_pkg::ET_BYTE:      total = (lw + 30'd7) >> 3;
      capv_pkg::ET_TWO:       total = (lw + 30'd3) >> 2;
      capv_pkg::ET_FOUR:      total = (lw + 30'd1) >> 1;
      capv_pkg::ET_EIGHT:     total = lw;
      capv_pkg::ET_PTR:       total = lw;
      capv_pkg::ET_COMPOSITE: total = lw + 30'd1;
      default:                total = 30'd0;
    endcase
  end

  // Bounds test, inclusive at both ends, and the check of the tag word.
  always_comb begin
    start33 = 33'(start);
    lo33    = 33'(in_dist_to_start);
    hi33    = signed'({3'b000, in_dist_to_end});
    if (typ == capv_pkg::PT_STRUCT) begin
      end33 = start33 + signed'({16'd0, ssize});
    end else begin
      end33 = start33 + signed'({3'd0, total});
    end
    start_ok = (start33 >= lo33) && (start33 <= hi33);
    end_ok   = (end33 >= lo33) && (end33 <= hi33);
    tag_bad  = (in_tag_word[1:0] != 2'b00) || (tsize == 17'd0);
  end

  // Classification into a status and the decoded layout.
  always_comb begin
    item_nxt        = '0;
    item_nxt.tgt    = start;
    item_nxt.size   = tsize;
    if (typ != capv_pkg::PT_STRUCT && typ != capv_pkg::PT_LIST) begin
      item_nxt.status = capv_pkg::ST_BAD_TYPE;
    end else if (typ == capv_pkg::PT_STRUCT && in_pointer_word == 64'd0) begin
      item_nxt.status = capv_pkg::ST_NULL;
    end else if (!start_ok) begin
      item_nxt.status = capv_pkg::ST_START_OUT;
    end else if (!end_ok) begin
      item_nxt.status = capv_pkg::ST_END_OUT;
    end else if (typ == capv_pkg::PT_STRUCT) begin
      item_nxt.status = capv_pkg::ST_OK;
      item_nxt.dw     = sdw;
      item_nxt.pc     = spc;
    end else if (et == capv_pkg::ET_COMPOSITE) begin
      item_nxt.status = tag_bad ? capv_pkg::ST_BAD_TAG : capv_pkg::ST_OK;
      item_nxt.kind   = 1'b1;
      item_nxt.tgt    = start + 31'sd1;
      item_nxt.dw     = tdw;
      item_nxt.pc     = tpc;
      item_nxt.ec     = len;
      item_nxt.et     = et;
      item_nxt.comp   = 1'b1;
    end else begin
      item_nxt.status = capv_pkg::ST_OK;
      item_nxt.kind   = 1'b1;
      item_nxt.dw     = {15'd0, et == capv_pkg::ET_EIGHT};
      item_nxt.pc     = {15'd0, et == capv_pkg::ET_PTR};
      item_nxt.ec     = len;
      item_nxt.stride = capv_pkg::stride_of(et);
      item_nxt.et     = et;
    end
  end

  // Holding register in front of the queue.
  assign in_full = vld_r && fq_full;
  assign fq_push = vld_r && !fq_full;
  assign fq_item = item_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_push && !in_full) begin
      vld_nxt = 1'b1;
    end else if (fq_push) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (in_push && !in_full) begin
      item_r <= item_nxt;
    end
  end

endmodule

/* src/capv_queue.sv */
`timescale 1ns / 1ps

module capv_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  capv_pkg::item_t  push_item,
  input  logic             pop,
  output logic             empty,
  output capv_pkg::item_t  pop_item
);

  capv_pkg::item_t  mem [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic             do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = mem[rp_r];

  // Two-entry circular buffer with an occupancy count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= !wp_r;
      end
      if (do_pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
    if (do_push) begin
      mem[wp_r] <= push_item;
    end
  end

endmodule

/* src/capv_back.sv */
`timescale 1ns / 1ps

module capv_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fq_empty,
  output logic                fq_pop,
  input  capv_pkg::item_t     fq_item,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [2:0]          out_status,
  output logic                out_pointer_kind,
  output logic signed [30:0]  out_target_offset,
  output logic [15:0]         out_data_words,
  output logic [15:0]         out_pointer_count,
  output logic [28:0]         out_element_count,
  output logic [19:0]         out_stride_bytes,
  output logic [2:0]          out_element_type
);

  localparam int NST = capv_pkg::LEN_W;

  capv_pkg::stage_t  pipe_r [NST];
  logic [NST-1:0]    vld_r;
  logic              adv, oq_full, oq_push, oq_pop;
  capv_pkg::stage_t  load;
  capv_pkg::item_t   fin;

  capv_pkg::item_t   oq_mem [4];
  logic [1:0]        owp_r, orp_r;
  logic [2:0]        ocnt_r;

  // The divider moves unless its last stage holds a word with nowhere to go.
  assign oq_full = (ocnt_r == 3'd4);
  assign adv     = !(vld_r[NST-1] && oq_full);
  assign fq_pop  = adv && !fq_empty;

  always_comb begin
    load     = '0;
    load.it  = fq_item;
    load.dvd = fq_item.ec;
    load     = capv_pkg::div_step(load);
  end

  // One quotient bit per stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], !fq_empty};
    end
    if (adv) begin
      pipe_r[0] <= load;
      for (int i = 1; i < NST; i++) begin
        pipe_r[i] <= capv_pkg::div_step(pipe_r[i-1]);
      end
    end
  end

  // Composite results and clearing of failed words.
  always_comb begin
    fin = pipe_r[NST-1].it;
    if (fin.status == capv_pkg::ST_OK && fin.comp) begin
      if (pipe_r[NST-1].rem != '0) begin
        fin.status = capv_pkg::ST_SIZE_MIS;
      end else begin
        fin.ec     = pipe_r[NST-1].quo;
        fin.stride = {fin.size, 3'b000};
      end
    end
    if (fin.status != capv_pkg::ST_OK) begin
      fin        = '0;
      fin.status = (pipe_r[NST-1].it.status == capv_pkg::ST_OK) ?
                   capv_pkg::ST_SIZE_MIS : pipe_r[NST-1].it.status;
    end
  end

  // Output queue of finished words.
  assign oq_push   = vld_r[NST-1] && !oq_full;
  assign out_empty = (ocnt_r == 3'd0);
  assign oq_pop    = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 2'd0;
      orp_r  <= 2'd0;
      ocnt_r <= 3'd0;
    end else begin
      if (oq_push) begin
        owp_r <= owp_r + 2'd1;
      end
      if (oq_pop) begin
        orp_r <= orp_r + 2'd1;
      end
      ocnt_r <= ocnt_r + {2'b00, oq_push} - {2'b00, oq_pop};
    end
    if (oq_push) begin
      oq_mem[owp_r] <= fin;
    end
  end

  assign out_status        = oq_mem[orp_r].status;
  assign out_pointer_kind  = oq_mem[orp_r].kind;
  assign out_target_offset = oq_mem[orp_r].tgt;
  assign out_data_words    = oq_mem[orp_r].dw;
  assign out_pointer_count = oq_mem[orp_r].pc;
  assign out_element_count = oq_mem[orp_r].ec;
  assign out_stride_bytes  = oq_mem[orp_r].stride;
  assign out_element_type  = oq_mem[orp_r].et;

endmodule

/* src/capnp_pointer_validator.sv */
`timescale 1ns / 1ps

// Decodes and bounds-checks one serialized struct or list pointer word per cycle.
// A word is taken every cycle while in_full is low; each gives one result word,
// in order, after classification and bounds checks into a holding register,
// a pass through a two-entry queue, and 29 stages of a restoring divider (one
// quotient bit per stage) that splits a composite list's word count by the tag's
// element size. The output side holds up to four finished words; when it backs
// up, the divider, then the queue, then in_full stall in turn.

module capnp_pointer_validator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [63:0]         in_pointer_word,
  input  logic [63:0]         in_tag_word,
  input  logic signed [29:0]  in_dist_to_start,
  input  logic [29:0]         in_dist_to_end,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [2:0]          out_status,
  output logic                out_pointer_kind,
  output logic signed [30:0]  out_target_offset,
  output logic [15:0]         out_data_words,
  output logic [15:0]         out_pointer_count,
  output logic [28:0]         out_element_count,
  output logic [19:0]         out_stride_bytes,
  output logic [2:0]          out_element_type
);

  logic             fq_push, fq_full, fq_pop, fq_empty;
  capv_pkg::item_t  fq_in, fq_out;

  capv_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_pointer_word  (in_pointer_word),
    .in_tag_word      (in_tag_word),
    .in_dist_to_start (in_dist_to_start),
    .in_dist_to_end   (in_dist_to_end),
    .fq_push          (fq_push),
    .fq_full          (fq_full),
    .fq_item          (fq_in)
  );

  capv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fq_push),
    .full      (fq_full),
    .push_item (fq_in),
    .pop       (fq_pop),
    .empty     (fq_empty),
    .pop_item  (fq_out)
  );

  capv_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .fq_empty          (fq_empty),
    .fq_pop            (fq_pop),
    .fq_item           (fq_out),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_status        (out_status),
    .out_pointer_kind  (out_pointer_kind),
    .out_target_offset (out_target_offset),
    .out_data_words    (out_data_words),
    .out_pointer_count (out_pointer_count),
    .out_element_count (out_element_count),
    .out_stride_bytes  (out_stride_bytes),
    .out_element_type  (out_element_type)
  );

  // A waiting result never carries a status code beyond size mismatch.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_status <= capv_pkg::ST_SIZE_MIS)
    else $error("status code out of range");

  // A failed word carries nothing but its status.
  a_fail_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != capv_pkg::ST_OK) |->
      (out_pointer_kind == 1'b0 && out_target_offset == 31'sd0 &&
       out_data_words == 16'd0 && out_pointer_count == 16'd0 &&
       out_element_count == 29'd0 && out_stride_bytes == 20'd0 &&
       out_element_type == 3'd0))
    else $error("failed word has nonzero fields");

  // A good composite word has a stride of eight bytes per element word.
  a_comp_stride: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status == capv_pkg::ST_OK &&
     out_element_type == capv_pkg::ET_COMPOSITE) |->
      out_stride_bytes == {({1'b0, out_data_words} + {1'b0, out_pointer_count}), 3'b000})
    else $error("composite stride mismatch");

  // A struct result reports no list fields.
  a_struct_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status == capv_pkg::ST_OK && !out_pointer_kind) |->
      (out_element_count == 29'd0 && out_element_type == 3'd0))
    else $error("struct word has list fields");

endmodule
